/* design/acpe_pkg.sv */
package acpe_pkg;

  // logical pixel colors
  localparam logic [1:0] COL_BLACK  = 2'h0;
  localparam logic [1:0] COL_BLUE   = 2'h1;
  localparam logic [1:0] COL_ORANGE = 2'h2;
  localparam logic [1:0] COL_WHITE  = 2'h3;

  // configuration register indexes
  localparam logic [1:0] CFG_COLOR_SWAP     = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_ROW  = 2'd1;
  localparam logic [1:0] CFG_ROWS_PER_FRAME = 2'd2;

  localparam logic [7:0] BYTES_PER_ROW_RST  = 8'd32;
  localparam logic [7:0] ROWS_PER_FRAME_RST = 8'd192;

  // output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic        last_result;
    logic        end_of_frame;
    logic        end_of_row;
    logic [15:0] pixel_word;
  } out_item_t;

  // map a logical color to its output code
  function automatic logic [1:0] to_code(logic [1:0] c, logic swap);
    logic [1:0] res;
    res = c;
    if (swap && (c == COL_BLUE)) res = COL_ORANGE;
    if (swap && (c == COL_ORANGE)) res = COL_BLUE;
    return res;
  endfunction

endpackage

/* design/acpe_lane.sv */
module acpe_lane import acpe_pkg::*; (
  input  logic [1:0] pair_i,
  input  logic [1:0] next_i,
  input  logic [1:0] left_i,
  output logic [1:0] pix_l_o,
  output logic [1:0] pix_r_o
);

  always_comb begin
    pix_l_o = pair_i;
    pix_r_o = pair_i;
    if ((pair_i == COL_BLUE) && ((next_i == COL_ORANGE) || (next_i == COL_WHITE))) begin
      pix_l_o = COL_BLACK;
      pix_r_o = COL_WHITE;
    end else if ((pair_i == COL_ORANGE) && ((left_i == COL_BLUE) || (left_i == COL_WHITE))) begin
      pix_l_o = COL_WHITE;
      pix_r_o = COL_BLACK;
    end
  end

endmodule

/* design/acpe_fix.sv */
module acpe_fix import acpe_pkg::*; (
  input  logic [7:0]  colors_i,
  input  logic [1:0]  next_i,
  input  logic [1:0]  left_i,
  input  logic        swap_i,
  output logic [15:0] word_o
);

  logic [1:0] pair_l [4];
  logic [1:0] pair_r [4];
  logic [1:0] lane_left [4];
  logic [1:0] lane_next [4];

  // four lanes, leftmost pair in lane 0; left neighbour ripples along
  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i == 0) begin : g_first
      assign lane_left[i] = left_i;
    end else begin : g_rest
      assign lane_left[i] = pair_r[i-1];
    end
    if (i == 3) begin : g_edge
      assign lane_next[i] = next_i;
    end else begin : g_inner
      assign lane_next[i] = colors_i[5-2*i -: 2];
    end
    acpe_lane u_lane (
      .pair_i  (colors_i[7-2*i -: 2]),
      .next_i  (lane_next[i]),
      .left_i  (lane_left[i]),
      .pix_l_o (pair_l[i]),
      .pix_r_o (pair_r[i])
    );
  end

  // merge: code mapping and word packing
  always_comb begin
    word_o = '0;
    for (int i = 0; i < 4; i++) begin
      word_o[15-4*i -: 2] = to_code(pair_l[i], swap_i);
      word_o[13-4*i -: 2] = to_code(pair_r[i], swap_i);
    end
  end

endmodule

/* design/artifact_color_pixel_expander.sv */
// artifact color pixel expander
//
// s_axis carries one source byte per item (eight 1-bit pixels, leftmost in
// bit 7). m_axis carries 16-bit words of eight 2-bit color pixels, with tlast
// marking the end of a row and tuser flagging the frame end and the last word
// caused by an input item. the cfg channel writes color_swap (index 0),
// bytes_per_row (index 1) and rows_per_frame (index 2); it is always ready
// and should only be written while the block is idle.
//
// each byte is held until the next byte of its row arrives, because the
// fix-up of its last pair needs the next pair. the last byte of a row emits
// the held word and its own word. results go into a 4-entry output queue and
// are registered there before they appear on m_axis.
// throughput: one byte per cycle while the queue has room; a row end that
// flushes two words needs a second read from the queue's single output port.
// s_axis_tready drops while the queue holds more than two words, so a
// stalled receiver backs up into the source without losing data.
// reset clears the held byte, position counters and queue, and loads the
// register defaults (no swap, 32 bytes per row, 192 rows per frame).
module artifact_color_pixel_expander import acpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // source bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  // color words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pixel_word
  output logic        m_axis_tlast,   // end_of_row
  output logic [1:0]  m_axis_tuser,   // [0] end_of_frame, [1] last_result
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // configuration registers
  logic       swap_q;
  logic [7:0] bytes_per_row_q, rows_per_frame_q;

  // row state
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic [1:0] prev_q, prev_d;
  logic [7:0] byte_cnt_q, byte_cnt_d;
  logic [7:0] row_cnt_q, row_cnt_d;

  // output queue
  out_item_t         oq_mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_rd_q, oq_rd_d, oq_wr_q, oq_wr_d, oq_wr_b;
  logic [OQ_CW-1:0]  oq_cnt_q, oq_cnt_d;

  logic       in_acc, out_acc;
  logic       row_end, frame_end;
  logic       push_a, push_b;
  logic [15:0] word_a, word_b;
  logic [1:0]  right_a, left_b;
  out_item_t   item_a, item_b, item_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q           <= 1'b0;
      bytes_per_row_q  <= BYTES_PER_ROW_RST;
      rows_per_frame_q <= ROWS_PER_FRAME_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLOR_SWAP:     swap_q           <= cfg_data_i[0];
        CFG_BYTES_PER_ROW:  bytes_per_row_q  <= cfg_data_i;
        CFG_ROWS_PER_FRAME: rows_per_frame_q <= cfg_data_i;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // room for two words keeps the ready independent of the output side
  assign s_axis_tready = (oq_cnt_q <= OQ_CW'(OQ_DEPTH - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // compare is >= so a lowered size ends the row or frame at once
  assign row_end   = ({1'b0, byte_cnt_q} + 9'd1) >= {1'b0, bytes_per_row_q};
  assign frame_end = ({1'b0, row_cnt_q} + 9'd1) >= {1'b0, rows_per_frame_q};

  // held byte, finished now that its right neighbour pair is known
  acpe_fix u_fix_held (
    .colors_i (held_q),
    .next_i   (s_axis_tdata[7:6]),
    .left_i   (prev_q),
    .swap_i   (swap_q),
    .word_o   (word_a)
  );

  // code mapping is its own inverse, so the rightmost pixel decodes back
  assign right_a = to_code(word_a[1:0], swap_q);

  // incoming byte at a row end, nothing to its right
  assign left_b = held_vld_q ? right_a : prev_q;

  acpe_fix u_fix_last (
    .colors_i (s_axis_tdata),
    .next_i   (COL_BLACK),
    .left_i   (left_b),
    .swap_i   (swap_q),
    .word_o   (word_b)
  );

  assign push_a = in_acc && held_vld_q;
  assign push_b = in_acc && row_end;

  always_comb begin
    item_a.pixel_word   = word_a;
    item_a.end_of_row   = 1'b0;
    item_a.end_of_frame = 1'b0;
    item_a.last_result  = !row_end;
    item_b.pixel_word   = word_b;
    item_b.end_of_row   = 1'b1;
    item_b.end_of_frame = frame_end;
    item_b.last_result  = 1'b1;
  end

  always_comb begin
    held_d     = held_q;
    held_vld_d = held_vld_q;
    prev_d     = prev_q;
    byte_cnt_d = byte_cnt_q;
    row_cnt_d  = row_cnt_q;
    if (in_acc) begin
      if (row_end) begin
        held_d     = '0;
        held_vld_d = 1'b0;
        prev_d     = COL_BLACK;
        byte_cnt_d = '0;
        row_cnt_d  = frame_end ? '0 : row_cnt_q + 8'd1;
      end else begin
        held_d     = s_axis_tdata;
        held_vld_d = 1'b1;
        prev_d     = held_vld_q ? right_a : prev_q;
        byte_cnt_d = byte_cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_vld_q <= 1'b0;
      prev_q     <= COL_BLACK;
      byte_cnt_q <= '0;
      row_cnt_q  <= '0;
    end else begin
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      prev_q     <= prev_d;
      byte_cnt_q <= byte_cnt_d;
      row_cnt_q  <= row_cnt_d;
    end
  end

  // output queue, up to two writes and one read per cycle
  assign oq_wr_b  = oq_wr_q + OQ_AW'(push_a);
  assign oq_wr_d  = oq_wr_q + OQ_AW'(push_a) + OQ_AW'(push_b);
  assign oq_rd_d  = oq_rd_q + OQ_AW'(out_acc);
  assign oq_cnt_d = oq_cnt_q + OQ_CW'(push_a) + OQ_CW'(push_b) - OQ_CW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_rd_q  <= '0;
      oq_wr_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_rd_q  <= oq_rd_d;
      oq_wr_q  <= oq_wr_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) oq_mem_q[oq_wr_q] <= item_a;
    if (push_b) oq_mem_q[oq_wr_b] <= item_b;
  end

  assign item_out      = oq_mem_q[oq_rd_q];
  assign m_axis_tvalid = (oq_cnt_q != '0);
  assign m_axis_tdata  = item_out.pixel_word;
  assign m_axis_tlast  = item_out.end_of_row;
  assign m_axis_tuser  = {item_out.last_result, item_out.end_of_frame};

  // queue never overfills
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  // with no byte held the left neighbour is the row start
  a_prev_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_vld_q |-> (prev_q == COL_BLACK))
    else $error("left pixel not black without held byte");

  // a row end word is always the last word of its item
  a_eor_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
    else $error("row end word not marked last");

  // a held byte implies the row has advanced
  a_held_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_vld_q |-> (byte_cnt_q != '0))
    else $error("held byte at row start");

endmodule
